### hw/rtl/cansx_pkg.sv
`default_nettype none

package cansx_pkg;

   localparam int NUM_REGS          = 4;
   localparam int NUM_ENTRIES_DEF   = 4;
   localparam int PAYLOAD_BYTES_DEF = 8;
   localparam int CSR_INDEX_W       = 4;
   localparam int VALUE_W           = 32;

   localparam logic [VALUE_W-1:0] NOT_RECEIVED = '1;
   localparam logic [5:0]         MAX_LENGTH   = 6'd32;

   typedef struct packed {
      logic       enable;
      logic [5:0] length;
      logic [5:0] start_bit;
      logic [10:0] id;
   } layout_type;

   localparam logic [23:0] LAYOUT_RESET [NUM_REGS] = '{
      24'd10486466, 24'd10552002, 24'd10486468, 24'd12583622
   };

   typedef struct packed {
      logic [10:0] frame_id;
      logic [63:0] payload;
   } req_type;

   typedef struct packed {
      logic               frame_accepted;
      logic [3:0]         updated_mask;
      logic [3:0]         layout_error;
      logic [VALUE_W-1:0] signal_value_0;
      logic [VALUE_W-1:0] signal_value_1;
      logic [VALUE_W-1:0] signal_value_2;
      logic [VALUE_W-1:0] signal_value_3;
   } rsp_type;

   typedef struct packed {
      logic hit;
      logic match;
      logic ok;
   } field_status_type;

endpackage

`default_nettype wire

### hw/rtl/can_signal_extractor_unit.sv
`default_nettype none

// CAN signal extractor. Each request beat carries one standard frame (id and eight
// payload bytes, byte 0 in the top bits). The frame passes the filter when an enabled
// table entry holds its id; every entry with that id then has its big-endian signal
// extracted and stored, and the response beat reports the filter result, the entries
// rewritten, the entries skipped for an impossible layout, and all stored values after
// the frame (all ones until first received). One beat is taken per clock unless a held
// response is stalled. A taken beat loads the input register; the result register, which
// also carries the stored-value update, loads from it when the output can advance. Layout
// registers 0..LIVE-1 (0..3 by default) are written through the csr port, which is always
// ready. The user must write them while the unit is idle; the block does not check it.
module can_signal_extractor_unit #(
   parameter int NUM_ENTRIES   = cansx_pkg::NUM_ENTRIES_DEF,
   parameter int PAYLOAD_BYTES = cansx_pkg::PAYLOAD_BYTES_DEF
) (
   input  var logic                                clock,
   input  var logic                                reset,
   input  var logic                                req_valid,
   output var logic                                req_stall,
   input  var cansx_pkg::req_type                  req_data,
   output var logic                                rsp_valid,
   input  var logic                                rsp_stall,
   output var cansx_pkg::rsp_type                  rsp_data,
   input  var logic                                csr_valid,
   output var logic                                csr_ready,
   input  var logic [cansx_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  var logic [23:0]                         csr_wdata
);
   import cansx_pkg::*;

   localparam int LIVE = (NUM_ENTRIES < NUM_REGS) ? NUM_ENTRIES : NUM_REGS;

   logic                s1_valid_ff;
   logic                s1_valid_in;
   req_type             s1_req_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;
   logic                advance;
   logic                take;
   logic                fire;
   logic                accepted;

   layout_type          layout_ff [LIVE];
   logic [VALUE_W-1:0]  values_ff [LIVE];
   logic [VALUE_W-1:0]  values_in [LIVE];
   field_status_type    status [LIVE];
   logic [VALUE_W-1:0]  extracted [LIVE];
   logic [LIVE-1:0]     hits;
   logic [3:0]          upd;
   logic [3:0]          err;
   logic [VALUE_W-1:0]  shown [NUM_REGS];

   assign csr_ready = 1'b1;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign fire      = advance && s1_valid_ff;
   assign accepted  = |hits;

   assign s1_valid_in  = take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   for (genvar i = 0; i < LIVE; i++) begin : g_entry
      cansx_field #(
         .PAYLOAD_BYTES (PAYLOAD_BYTES)
      ) u_field (
         .layout   (layout_ff[i]),
         .frame_id (s1_req_ff.frame_id),
         .payload  (s1_req_ff.payload),
         .status   (status[i]),
         .value    (extracted[i])
      );

      assign hits[i]      = status[i].hit;
      assign upd[i]       = accepted && status[i].match && status[i].ok;
      assign err[i]       = accepted && status[i].match && !status[i].ok;
      assign values_in[i] = upd[i] ? extracted[i] : values_ff[i];

      always_ff @(posedge clock) begin
         if (reset) begin
            layout_ff[i] <= layout_type'(LAYOUT_RESET[i]);
            values_ff[i] <= NOT_RECEIVED;
         end else begin
            if (csr_valid && csr_ready && (csr_index == CSR_INDEX_W'(i))) begin
               layout_ff[i] <= layout_type'(csr_wdata);
            end
            if (fire) begin
               values_ff[i] <= values_in[i];
            end
         end
      end
   end

   for (genvar k = 0; k < NUM_REGS; k++) begin : g_show
      if (k < LIVE) begin : g_live
         assign shown[k] = values_in[k];
      end else begin : g_absent
         assign shown[k] = NOT_RECEIVED;
         assign upd[k]   = 1'b0;
         assign err[k]   = 1'b0;
      end
   end

   always_comb begin
      rsp_in.frame_accepted = accepted;
      rsp_in.updated_mask   = upd;
      rsp_in.layout_error   = err;
      rsp_in.signal_value_0 = shown[0];
      rsp_in.signal_value_1 = shown[1];
      rsp_in.signal_value_2 = shown[2];
      rsp_in.signal_value_3 = shown[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_req_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### hw/rtl/cansx_field.sv
`default_nettype none

module cansx_field #(
   parameter int PAYLOAD_BYTES = cansx_pkg::PAYLOAD_BYTES_DEF
) (
   input  var cansx_pkg::layout_type       layout,
   input  var logic [10:0]                 frame_id,
   input  var logic [63:0]                 payload,
   output var cansx_pkg::field_status_type status,
   output var logic [cansx_pkg::VALUE_W-1:0] value
);
   import cansx_pkg::*;

   logic [2:0]  first;
   logic [2:0]  offset;
   logic [2:0]  nbytes;
   logic [5:0]  rem_full;
   logic [3:0]  rem;
   logic        len_ok;
   logic        fits;
   logic        edge_ok;
   logic [63:0] shifted;
   logic [31:0] win;
   logic [23:0] whole;
   logic [7:0]  lastb;
   logic [7:0]  mask;
   logic [7:0]  last_bits;

   assign first    = layout.start_bit[5:3];
   assign offset   = layout.start_bit[2:0];
   assign nbytes   = 3'((7'(layout.length) + 7'd7) >> 3);
   assign rem_full = layout.length - {nbytes - 3'd1, 3'b000};
   assign rem      = rem_full[3:0];

   assign len_ok  = (layout.length != 6'd0) && (layout.length <= MAX_LENGTH);
   assign fits    = ({1'b0, first} + {1'b0, nbytes}) <= 4'(PAYLOAD_BYTES);
   assign edge_ok = ({1'b0, offset} + rem) <= 4'd8;

   assign shifted = payload << {first, 3'b000};
   assign win     = shifted[63:32];

   always_comb begin
      case (nbytes)
         3'd1: begin
            whole = 24'd0;
            lastb = win[31:24];
         end
         3'd2: begin
            whole = {16'd0, win[31:24]};
            lastb = win[23:16];
         end
         3'd3: begin
            whole = {8'd0, win[31:16]};
            lastb = win[15:8];
         end
         default: begin
            whole = win[31:8];
            lastb = win[7:0];
         end
      endcase
   end

   assign mask      = 8'((9'h1 << rem) - 9'h1);
   assign last_bits = (lastb >> offset) & mask;
   assign value     = (32'(whole) << rem) | 32'(last_bits);

   assign status.match = (layout.id == frame_id);
   assign status.hit   = status.match && layout.enable;
   assign status.ok    = len_ok && fits && edge_ok;

endmodule

`default_nettype wire
